>>> rtl/dqmrp_pkg.sv
// Shared types and constants of the data-quality run painter.
// Used by the interfaces' users, the sequencer and the top level; depends on nothing.
package dqmrp_pkg;

    // Coordinate width: a 16-bit start plus shift, offset and run length still fits.
    localparam int CW = 19;
    typedef logic signed [CW-1:0] t_coord;

    // Request types.
    localparam logic [1:0] REQ_PAINT = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Run axes.
    localparam logic [1:0] AXIS_X = 2'd1;
    localparam logic [1:0] AXIS_Y = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_X_OFFSET     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_Y_OFFSET     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_SHIFT_ENABLE = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_COLUMN_SPLIT = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_COLUMN_SHIFT = 3'd4;

    typedef struct packed {
        logic signed [12:0] x_offset;
        logic signed [12:0] y_offset;
        logic               shift_enable;
        logic [12:0]        column_split;
        logic [9:0]         column_shift;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [12:0]        run_length;
        logic [1:0]         run_axis;
        logic [15:0]        flag_value;
    } t_req;

    typedef struct packed {
        logic [15:0] read_value;
        logic [12:0] pixels_touched;
        logic [1:0]  status_code;
    } t_res;

endpackage

>>> rtl/dqmrp_ifs.sv
// Handshake interfaces of the data-quality run painter: request, result and
// configuration channels. Each carries valid, ready and its payload; no dependencies.
interface dqmrp_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [12:0]        run_length;
    logic [1:0]         run_axis;
    logic [15:0]        flag_value;

    modport source (output valid, req_type, start_x, start_y, run_length, run_axis,
                    flag_value, input ready);
    modport sink (input valid, req_type, start_x, start_y, run_length, run_axis,
                  flag_value, output ready);
endinterface

interface dqmrp_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_value;
    logic [12:0] pixels_touched;
    logic [1:0]  status_code;

    modport source (output valid, read_value, pixels_touched, status_code, input ready);
    modport sink (input valid, read_value, pixels_touched, status_code, output ready);
endinterface

interface dqmrp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/dq_mask_run_painter_top.sv
// Top level of the data-quality run painter: configuration registers, channel
// wiring, the sequencer and the flag image memory. Depends on dqmrp_pkg,
// the dqmrp interfaces, dqmrp_seq and dqmrp_mem.
//
// The block holds a COLS x ROWS image of 16-bit flag words in one single-port-
// write, single-port-read memory. After reset a clearing pass writes zero to every
// word, one word a cycle; no request item is taken meanwhile, while configuration
// writes are taken at all times. One request item is handled at a time. A paint
// passes through the setup steps (shift, offsets, span, clip, start address), then
// one read-modify-write per cycle through the memory's read and write ports, then
// the last write-back, the load of the output register and the offered result;
// the load waits while the output register still holds an untaken result. A
// rejected paint ends after the shift step and an off-image paint after the clip
// step. A finished result sits in an output register; a new item is accepted as
// soon as the previous result is loaded there.
module dq_mask_run_painter_top
    import dqmrp_pkg::*;
#(
    parameter int COLS = 256,
    parameter int ROWS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dqmrp_cfg_if.sink   i_cfg,
    dqmrp_req_if.sink   i_req,
    dqmrp_res_if.source o_res
);

    localparam int DEPTH = COLS * ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg          r_cfg;
    t_req          req;
    t_res          res;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    // Configuration registers, written whenever the port offers an item.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_X_OFFSET:     r_cfg.x_offset     <= $signed(i_cfg.data);
                CFG_Y_OFFSET:     r_cfg.y_offset     <= $signed(i_cfg.data);
                CFG_SHIFT_ENABLE: r_cfg.shift_enable <= i_cfg.data[0];
                CFG_COLUMN_SPLIT: r_cfg.column_split <= i_cfg.data;
                CFG_COLUMN_SHIFT: r_cfg.column_shift <= i_cfg.data[9:0];
                default: begin
                end
            endcase
        end
    end

    // Request and result payloads gathered into structs.
    assign req.req_type   = i_req.req_type;
    assign req.start_x    = i_req.start_x;
    assign req.start_y    = i_req.start_y;
    assign req.run_length = i_req.run_length;
    assign req.run_axis   = i_req.run_axis;
    assign req.flag_value = i_req.flag_value;

    assign o_res.read_value     = res.read_value;
    assign o_res.pixels_touched = res.pixels_touched;
    assign o_res.status_code    = res.status_code;

    dqmrp_seq #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (req),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res       (res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    dqmrp_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

>>> rtl/dqmrp_mem.sv
// Flag image storage: one write port and one read port with registered read data.
// Depends on nothing; instantiated by the top level.
module dqmrp_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [15:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [15:0]   o_rd_data
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data registered and valid in the cycle after the read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/dqmrp_seq.sv
// Sequencer and datapath of the run painter: coordinate setup, clipping, the
// per-pixel read-modify-write loop, pixel access and the clearing pass.
// Depends on dqmrp_pkg; drives the ports of dqmrp_mem.
module dqmrp_seq
    import dqmrp_pkg::*;
#(
    parameter int COLS = 256,
    parameter int ROWS = 256,
    localparam int DEPTH = COLS * ROWS,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  t_req          i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_res          o_res,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [15:0]   i_rd_data,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [15:0]   o_wr_data
);

    localparam t_coord COLS_C = t_coord'(COLS);
    localparam t_coord ROWS_C = t_coord'(ROWS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SHIFT, S_OFFS, S_SPAN, S_CLIP, S_ADDR,
        S_RUN, S_DRAIN, S_PIX, S_PIXACC, S_PIXRD, S_FIN
    } t_state;

    t_state        r_state;
    t_req          r_req;
    t_res          r_res;
    t_res          r_out;
    logic          r_out_vld;
    t_coord        r_x;
    t_coord        r_y;
    t_coord        r_lo;
    t_coord        r_hi;
    t_coord        r_fix;
    logic          r_in;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_step;
    logic [12:0]   r_left;
    logic [12:0]   r_cnt;
    logic          r_wb_vld;
    logic [AW-1:0] r_wb_addr;

    t_coord        sx;
    t_coord        sy;
    t_coord        len_m1;
    logic          apply_shift;
    logic          is_x;
    logic          bad_req;
    t_coord        lim_span;
    t_coord        lim_fix;
    logic          run_out;
    logic          pix_in;
    logic [AW-1:0] run_row;
    logic [AW-1:0] run_col;
    logic          load_out;

    // Decoded request and limits for the current run.
    always_comb begin
        sx          = t_coord'($signed(r_req.start_x));
        sy          = t_coord'($signed(r_req.start_y));
        len_m1      = t_coord'({1'b0, r_req.run_length}) - t_coord'(1);
        apply_shift = i_cfg.shift_enable
                      && (sx >= t_coord'({1'b0, i_cfg.column_split}));
        is_x        = (r_req.run_axis == AXIS_X);
        bad_req     = (r_req.run_length == '0)
                      || ((r_req.run_axis != AXIS_X) && (r_req.run_axis != AXIS_Y));
        lim_span    = is_x ? COLS_C : ROWS_C;
        lim_fix     = is_x ? ROWS_C : COLS_C;
        run_out     = (r_hi < 0) || (r_lo >= lim_span) || (r_fix < 0) || (r_fix >= lim_fix);
        pix_in      = (sx >= 0) && (sx < COLS_C) && (sy >= 0) && (sy < ROWS_C);
        run_row     = AW'($unsigned(is_x ? r_fix : r_lo));
        run_col     = AW'($unsigned(is_x ? r_lo : r_fix));
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

    // A finished result moves to the output register once that register is free.
    assign load_out = (r_state == S_FIN) && (!r_out_vld || i_res_ready);

    // Memory port control: clearing writes, run reads, pixel access and write-back.
    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = r_addr;
        o_wr_en   = 1'b0;
        o_wr_addr = r_addr;
        o_wr_data = '0;
        case (r_state)
            S_CLR: begin
                o_wr_en = 1'b1;
            end
            S_RUN: begin
                o_rd_en = 1'b1;
            end
            S_PIXACC: begin
                if (r_in && (r_req.req_type == REQ_WRITE)) begin
                    o_wr_en   = 1'b1;
                    o_wr_data = r_req.flag_value;
                end else if (r_in) begin
                    o_rd_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (r_wb_vld) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_wb_addr;
            o_wr_data = i_rd_data | r_req.flag_value;
        end
    end

    // Sequencer with its datapath registers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_out_vld <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_wb_vld <= (r_state == S_RUN);
            if (load_out) begin
                r_out     <= r_res;
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_res_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req <= i_req;
                        r_res <= '0;
                        case (i_req.req_type) inside
                            REQ_PAINT:            r_state <= S_SHIFT;
                            REQ_READ, REQ_WRITE:  r_state <= S_PIX;
                            default:              r_state <= S_FIN;
                        endcase
                    end
                end
                S_SHIFT: begin
                    if (bad_req) begin
                        r_res.status_code <= ST_BAD;
                        r_state           <= S_FIN;
                    end else begin
                        r_x     <= sx + (apply_shift ? t_coord'({1'b0, i_cfg.column_shift})
                                                     : t_coord'(0));
                        r_state <= S_OFFS;
                    end
                end
                S_OFFS: begin
                    r_x     <= r_x + t_coord'($signed(i_cfg.x_offset));
                    r_y     <= sy + t_coord'($signed(i_cfg.y_offset));
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    r_lo    <= is_x ? r_x : r_y;
                    r_hi    <= (is_x ? r_x : r_y) + len_m1;
                    r_fix   <= is_x ? r_y : r_x;
                    r_state <= S_CLIP;
                end
                S_CLIP: begin
                    if (run_out) begin
                        r_res.status_code <= ST_OUTSIDE;
                        r_state           <= S_FIN;
                    end else begin
                        r_lo    <= (r_lo < 0) ? t_coord'(0) : r_lo;
                        r_hi    <= (r_hi >= lim_span) ? (lim_span - t_coord'(1)) : r_hi;
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_left  <= 13'(r_hi - r_lo + t_coord'(1));
                    r_cnt   <= 13'(r_hi - r_lo + t_coord'(1));
                    r_addr  <= run_row * AW'(COLS) + run_col;
                    r_step  <= is_x ? AW'(1) : AW'(COLS);
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    // One pixel read per cycle; its OR and write follow in the next cycle.
                    r_wb_addr <= r_addr;
                    r_addr    <= r_addr + r_step;
                    r_left    <= r_left - 13'd1;
                    if (r_left == 13'd1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_res.pixels_touched <= r_cnt;
                    r_res.status_code    <= ST_OK;
                    r_state              <= S_FIN;
                end
                S_PIX: begin
                    r_in    <= pix_in;
                    r_addr  <= AW'($unsigned(sy)) * AW'(COLS) + AW'($unsigned(sx));
                    r_state <= S_PIXACC;
                end
                S_PIXACC: begin
                    r_res.status_code <= r_in ? ST_OK : ST_RANGE;
                    if (r_in && (r_req.req_type == REQ_READ)) begin
                        r_state <= S_PIXRD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_PIXRD: begin
                    r_res.read_value <= i_rd_data;
                    r_state          <= S_FIN;
                end
                S_FIN: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the data-quality run painter: a directed table, then random
// paint, read and write items under several register settings, all checked in order.
// Depends on the RTL package dqmrp_pkg, the dqmrp interfaces and dq_mask_run_painter_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dqmrp_pkg::*;

    localparam int IMG_COLS = 256;
    localparam int IMG_ROWS = 256;

    // Codes that the package does not name.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] AXIS_NONE  = 2'd0;
    localparam logic [1:0] AXIS_BAD   = 2'd3;

    // Directed rows either carry a typed-in result or defer to the flag image model.
    localparam logic FIXED   = 1'b1;
    localparam logic PREDICT = 1'b0;

    localparam int ITEMS_PER_SETTING = 205;
    localparam int HOLD_AT_RESULT    = 500;
    localparam int HOLD_CYCLES       = 400;
    localparam int DRAIN_CYCLES      = 300;
    localparam int MAX_PRINTED       = 50;

    typedef struct packed {
        t_req item;
        logic fixed;
        t_res res;
    } t_row;

    logic clk;
    logic rst_n;

    dqmrp_cfg_if cfg_if();
    dqmrp_req_if req_if();
    dqmrp_res_if res_if();

    dq_mask_run_painter_top #(
        .COLS(IMG_COLS),
        .ROWS(IMG_ROWS)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg(cfg_if),
        .i_req(req_if),
        .o_res(res_if)
    );

    // Bench copy of the flag image and of the registers.
    logic [15:0] flag_img [0:IMG_COLS*IMG_ROWS-1];
    int cfg_x_off    = 0;
    int cfg_y_off    = 0;
    int cfg_shift_en = 0;
    int cfg_split    = 0;
    int cfg_shift    = 0;

    t_res expected_results[$];
    t_row dir_rows[$];
    int   fail_count   = 0;
    int   results_seen = 0;
    int   idle_pct     = 14;

    // Clock.
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Timeout.
    initial begin
        #25_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Prints one mismatch line and counts it.
    task automatic note_mismatch(string msg);
        if (fail_count < MAX_PRINTED) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        fail_count++;
    endtask

    // Applies one request to the bench image and returns the result it gives.
    function automatic t_res flag_image_step(t_req r);
        t_res res;
        int sx, sy, len, x, y, lo, hi;
        res = '0;
        sx  = int'($signed(r.start_x));
        sy  = int'($signed(r.start_y));
        len = int'(r.run_length);
        case (r.req_type)
            REQ_PAINT: begin
                if (len == 0 || (r.run_axis != AXIS_X && r.run_axis != AXIS_Y)) begin
                    res.status_code = ST_BAD;
                end else begin
                    // Column shift for positions at or past the split, then the offsets.
                    x = sx;
                    if (cfg_shift_en != 0 && x >= cfg_split) begin
                        x += cfg_shift;
                    end
                    x += cfg_x_off;
                    y = sy + cfg_y_off;
                    if (r.run_axis == AXIS_X) begin
                        lo = x;
                        hi = x + len - 1;
                        if (hi < 0 || lo >= IMG_COLS || y < 0 || y >= IMG_ROWS) begin
                            res.status_code = ST_OUTSIDE;
                        end else begin
                            if (lo < 0) lo = 0;
                            if (hi >= IMG_COLS) hi = IMG_COLS - 1;
                            for (int k = lo; k <= hi; k++) begin
                                flag_img[y*IMG_COLS + k] |= r.flag_value;
                            end
                            res.pixels_touched = 13'(hi - lo + 1);
                        end
                    end else begin
                        lo = y;
                        hi = y + len - 1;
                        if (x < 0 || x >= IMG_COLS || hi < 0 || lo >= IMG_ROWS) begin
                            res.status_code = ST_OUTSIDE;
                        end else begin
                            if (lo < 0) lo = 0;
                            if (hi >= IMG_ROWS) hi = IMG_ROWS - 1;
                            for (int k = lo; k <= hi; k++) begin
                                flag_img[k*IMG_COLS + x] |= r.flag_value;
                            end
                            res.pixels_touched = 13'(hi - lo + 1);
                        end
                    end
                end
            end
            REQ_READ: begin
                if (sx >= 0 && sx < IMG_COLS && sy >= 0 && sy < IMG_ROWS) begin
                    res.read_value = flag_img[sy*IMG_COLS + sx];
                end else begin
                    res.status_code = ST_RANGE;
                end
            end
            REQ_WRITE: begin
                if (sx >= 0 && sx < IMG_COLS && sy >= 0 && sy < IMG_ROWS) begin
                    flag_img[sy*IMG_COLS + sx] = r.flag_value;
                end else begin
                    res.status_code = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Adds one line to the directed table.
    function automatic void dir_row(logic [1:0] rt, int sx, int sy, int len, logic [1:0] ax,
                                    int flag, logic fix, int rv, int pt, logic [1:0] st);
        t_row row;
        row.item.req_type   = rt;
        row.item.start_x    = 16'(sx);
        row.item.start_y    = 16'(sy);
        row.item.run_length = 13'(len);
        row.item.run_axis   = ax;
        row.item.flag_value = 16'(flag);
        row.fixed              = fix;
        row.res.read_value     = 16'(rv);
        row.res.pixels_touched = 13'(pt);
        row.res.status_code    = st;
        dir_rows.push_back(row);
    endfunction

    // Picks a coordinate: mostly a small hot corner, some anywhere, a few in a wider band.
    function automatic int pick_coord(int span);
        int p;
        p = $urandom_range(99);
        if (p < 50) return int'($urandom_range(31));
        if (p < 90) return int'($urandom_range(span - 1));
        return int'($urandom_range(span + 79)) - 40;
    endfunction

    // Builds one random request, aimed at the image through the current settings.
    function automatic t_req rand_request();
        t_req r;
        int kind, tx, ty, sx0, p;
        r = '0;
        kind = $urandom_range(99);
        r.flag_value = ($urandom_range(99) < 70) ? 16'(1 << $urandom_range(15))
                                                 : 16'($urandom);
        if (kind < 10) begin
            // Noise: random values in every field.
            r.req_type   = (kind < 2) ? REQ_UNUSED : 2'($urandom_range(2));
            r.start_x    = 16'($urandom);
            r.start_y    = 16'($urandom);
            r.run_length = 13'($urandom_range(4096));
            r.run_axis   = 2'($urandom_range(3));
        end else begin
            tx = pick_coord(IMG_COLS);
            ty = pick_coord(IMG_ROWS);
            if (kind < 62) begin
                // Paint whose start is worked back from the target pixel.
                r.req_type = REQ_PAINT;
                sx0 = tx - cfg_x_off;
                if (cfg_shift_en != 0 && sx0 - cfg_shift >= cfg_split) begin
                    sx0 -= cfg_shift;
                end
                r.start_x = 16'(sx0);
                r.start_y = 16'(ty - cfg_y_off);
                p = $urandom_range(99);
                r.run_axis = (p < 45) ? AXIS_X : (p < 90) ? AXIS_Y :
                             (p < 95) ? AXIS_NONE : AXIS_BAD;
                p = $urandom_range(99);
                if (p < 3)       r.run_length = 13'd0;
                else if (p < 55) r.run_length = 13'($urandom_range(1, 8));
                else if (p < 80) r.run_length = 13'($urandom_range(9, 64));
                else if (p < 93) r.run_length = 13'($urandom_range(65, 300));
                else if (p < 98) r.run_length = 13'($urandom_range(301, 4095));
                else             r.run_length = 13'd4096;
            end else begin
                r.req_type   = (kind < 80) ? REQ_WRITE : REQ_READ;
                r.start_x    = 16'(tx);
                r.start_y    = 16'(ty);
                r.run_length = 13'($urandom_range(4096));
                r.run_axis   = 2'($urandom_range(3));
            end
        end
        return r;
    endfunction

    // Offers one item until it is taken, then records its expected result.
    task automatic offer_item(t_req item, logic fix, t_res fixed_res);
        t_res predicted;
        req_if.valid      <= 1'b1;
        req_if.req_type   <= item.req_type;
        req_if.start_x    <= item.start_x;
        req_if.start_y    <= item.start_y;
        req_if.run_length <= item.run_length;
        req_if.run_axis   <= item.run_axis;
        req_if.flag_value <= item.flag_value;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        predicted = flag_image_step(item);
        expected_results.push_back(fix ? fixed_res : predicted);
    endtask

    // Random gap between items on the request side.
    task automatic request_gap();
        if ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // Writes one register; the caller lowers valid after its last write.
    task automatic write_reg(logic [CFG_IW-1:0] idx, int value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= 13'(value);
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (idx)
            CFG_X_OFFSET:     cfg_x_off    = int'($signed(13'(value)));
            CFG_Y_OFFSET:     cfg_y_off    = int'($signed(13'(value)));
            CFG_SHIFT_ENABLE: cfg_shift_en = value & 1;
            CFG_COLUMN_SPLIT: cfg_split    = value & 13'h1FFF;
            CFG_COLUMN_SHIFT: cfg_shift    = value & 10'h3FF;
            default: begin
            end
        endcase
    endtask

    // Loads a full register setting and runs a batch of random items under it.
    task automatic run_setting(int xo, int yo, int en, int split, int shift);
        write_reg(CFG_X_OFFSET, xo);
        write_reg(CFG_Y_OFFSET, yo);
        write_reg(CFG_SHIFT_ENABLE, en);
        write_reg(CFG_COLUMN_SPLIT, split);
        write_reg(CFG_COLUMN_SHIFT, shift);
        cfg_if.valid <= 1'b0;
        for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
            offer_item(rand_request(), PREDICT, '0);
            request_gap();
        end
        req_if.valid <= 1'b0;
        wait_results_drained();
    endtask

    // Result side: checks each taken item against the oldest expectation, stalls at
    // random, and once holds off long enough for the block to back up its input.
    initial begin
        t_res want;
        logic held;
        held = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("result item with no expectation pending");
                end else begin
                    want = expected_results.pop_front();
                    if (res_if.read_value !== want.read_value)
                        note_mismatch($sformatf("read_value got %h want %h",
                                                res_if.read_value, want.read_value));
                    if (res_if.pixels_touched !== want.pixels_touched)
                        note_mismatch($sformatf("pixels_touched got %0d want %0d",
                                                res_if.pixels_touched, want.pixels_touched));
                    if (res_if.status_code !== want.status_code)
                        note_mismatch($sformatf("status_code got %0d want %0d",
                                                res_if.status_code, want.status_code));
                end
                results_seen++;
            end
            if (!held && results_seen == HOLD_AT_RESULT) begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Stimulus.
    initial begin
        t_row row;
        rst_n             <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_X_OFFSET;
        cfg_if.data       <= '0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= REQ_PAINT;
        req_if.start_x    <= '0;
        req_if.start_y    <= '0;
        req_if.run_length <= '0;
        req_if.run_axis   <= AXIS_NONE;
        req_if.flag_value <= '0;
        foreach (flag_img[i]) flag_img[i] = '0;

        // Directed table, run at the reset register values.
        //      type        x       y       len   axis       flag     fix      rd       px  status
        dir_row(REQ_READ,   0,      0,      0,    AXIS_NONE, 0,       FIXED,   0,       0,  ST_OK);
        dir_row(REQ_READ,   255,    255,    0,    AXIS_NONE, 0,       FIXED,   0,       0,  ST_OK);
        dir_row(REQ_READ,   -1,     0,      0,    AXIS_NONE, 0,       FIXED,   0,       0,  ST_RANGE);
        dir_row(REQ_READ,   256,    0,      0,    AXIS_NONE, 0,       FIXED,   0,       0,  ST_RANGE);
        dir_row(REQ_READ,   0,      -32768, 0,    AXIS_NONE, 0,       FIXED,   0,       0,  ST_RANGE);
        dir_row(REQ_READ,   32767,  0,      0,    AXIS_NONE, 0,       FIXED,   0,       0,  ST_RANGE);
        dir_row(REQ_WRITE,  255,    255,    4096, AXIS_BAD,  'hFFFF,  FIXED,   0,       0,  ST_OK);
        dir_row(REQ_READ,   255,    255,    0,    AXIS_NONE, 0,       FIXED,   'hFFFF,  0,  ST_OK);
        dir_row(REQ_WRITE,  0,      256,    0,    AXIS_NONE, 'h1234,  FIXED,   0,       0,  ST_RANGE);
        dir_row(REQ_PAINT,  0,      0,      0,    AXIS_X,    'h0001,  FIXED,   0,       0,  ST_BAD);
        dir_row(REQ_PAINT,  0,      0,      5,    AXIS_NONE, 'h0001,  FIXED,   0,       0,  ST_BAD);
        dir_row(REQ_PAINT,  0,      0,      5,    AXIS_BAD,  'h0001,  FIXED,   0,       0,  ST_BAD);
        dir_row(REQ_PAINT,  -999,   -999,   0,    AXIS_NONE, 'h0001,  FIXED,   0,       0,  ST_BAD);
        dir_row(REQ_PAINT,  256,    0,      1,    AXIS_X,    'h0002,  FIXED,   0,       0,  ST_OUTSIDE);
        dir_row(REQ_PAINT,  -10,    0,      10,   AXIS_X,    'h0002,  FIXED,   0,       0,  ST_OUTSIDE);
        dir_row(REQ_PAINT,  0,      -1,     10,   AXIS_X,    'h0002,  FIXED,   0,       0,  ST_OUTSIDE);
        dir_row(REQ_PAINT,  -1,     0,      10,   AXIS_Y,    'h0002,  FIXED,   0,       0,  ST_OUTSIDE);
        dir_row(REQ_PAINT,  0,      -5,     5,    AXIS_Y,    'h0002,  FIXED,   0,       0,  ST_OUTSIDE);
        dir_row(REQ_PAINT,  -32768, 32767,  1,    AXIS_X,    'h0002,  FIXED,   0,       0,  ST_OUTSIDE);
        dir_row(REQ_PAINT,  -10,    3,      20,   AXIS_X,    'h0004,  FIXED,   0,       10, ST_OK);
        dir_row(REQ_PAINT,  0,      0,      4096, AXIS_Y,    'h8000,  FIXED,   0,       256, ST_OK);
        dir_row(REQ_PAINT,  250,    7,      4096, AXIS_X,    'h0001,  FIXED,   0,       6,  ST_OK);
        dir_row(REQ_UNUSED, -1,     -1,     4096, AXIS_BAD,  'hFFFF,  FIXED,   0,       0,  ST_OK);
        dir_row(REQ_READ,   5,      3,      0,    AXIS_NONE, 0,       PREDICT, 0,       0,  ST_OK);
        dir_row(REQ_READ,   0,      3,      0,    AXIS_NONE, 0,       PREDICT, 0,       0,  ST_OK);
        dir_row(REQ_READ,   255,    7,      0,    AXIS_NONE, 0,       PREDICT, 0,       0,  ST_OK);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            offer_item(row.item, row.fixed, row.res);
            request_gap();
        end
        req_if.valid <= 1'b0;
        wait_results_drained();

        // Random batches under a spread of register settings, extremes included.
        run_setting(0, 0, 0, 0, 0);
        idle_pct = 0;
        run_setting(13, -7, 1, 128, 37);
        idle_pct = 14;
        run_setting(-4096, 4095, 1, 0, 1023);
        run_setting(4095, -4096, 1, 8191, 0);
        run_setting(int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300,
                    int'($urandom_range(1)), int'($urandom_range(300)),
                    int'($urandom_range(1023)));
        run_setting(int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300,
                    1, int'($urandom_range(300)), int'($urandom_range(1023)));

        // Let any stray result item show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
